/* hdl/rlpm_pkg.sv */
package rlpm_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned LPM_CELLS       = 8;
  localparam int unsigned CELL_W          = $clog2(LPM_CELLS);

  // Field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 4;
  localparam int unsigned EIDX_W   = 10;
  localparam int unsigned S_DATA_W = 144;
  localparam int unsigned M_DATA_W = 48;

  // Request kinds carried on tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Input request payload, last field in the lowest bits
  typedef struct packed {
    logic [0:0]        pad;
    logic [ADDR_W-1:0] lookup_address;
    logic [PORT_W-1:0] route_port;
    logic [ADDR_W-1:0] route_next_hop;
    logic [ADDR_W-1:0] route_mask;
    logic [ADDR_W-1:0] route_prefix;
    logic              entry_enable;
    logic [EIDX_W-1:0] entry_index;
  } s_data_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [1:0]        pad;
    logic [EIDX_W-1:0] matched_index;
    logic [PORT_W-1:0] out_port;
    logic [ADDR_W-1:0] next_hop_address;
  } m_data_t;

  // One stored route
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

  // Write / clear command broadcast to all cells
  typedef struct packed {
    logic              data_we;
    logic              vbit_we;
    logic              bcast;
    logic              valid;
    logic [CELL_W-1:0] bank;
    entry_t            entry;
  } wr_t;

  // Token control traveling down the chain
  typedef struct packed {
    logic vld;
    logic last;
  } tok_t;

  // Best candidate so far
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } cand_t;

endpackage

/* hdl/rlpm_cell.sv */
module rlpm_cell #(
  parameter int unsigned TABLE_DEPTH = rlpm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned CELL_ID     = 0,
  localparam int unsigned ROWS  = (TABLE_DEPTH + rlpm_pkg::LPM_CELLS - 1) / rlpm_pkg::LPM_CELLS,
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned IDX_W = ROW_W + rlpm_pkg::CELL_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rlpm_pkg::wr_t                 wr_i,
  input  logic [ROW_W-1:0]              wr_row_i,
  input  logic [rlpm_pkg::ADDR_W-1:0]   addr_i,
  input  rlpm_pkg::tok_t                tok_i,
  input  logic [ROW_W-1:0]              row_i,
  input  rlpm_pkg::cand_t               cand_i,
  input  logic [IDX_W-1:0]              cidx_i,
  output rlpm_pkg::tok_t                tok_o,
  output logic [ROW_W-1:0]              row_o,
  output rlpm_pkg::cand_t               cand_o,
  output logic [IDX_W-1:0]              cidx_o
);

  // Local bank: rows of entries whose index modulo the cell count is CELL_ID
  rlpm_pkg::entry_t mem   [ROWS];
  logic             vbits [ROWS];

  rlpm_pkg::entry_t rd_q;
  logic             vbit_q;
  rlpm_pkg::tok_t   tok_q, tok2_q;
  logic [ROW_W-1:0] row_q, row2_q;
  rlpm_pkg::cand_t  cand_q, cand2_q, cand_d;
  logic [IDX_W-1:0] cidx_q, cidx2_q, cidx_d;
  logic             sel, match, take;

  assign sel = wr_i.bcast || (wr_i.bank == rlpm_pkg::CELL_W'(CELL_ID));

  // Bank write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.data_we && sel) begin
      mem[wr_row_i] <= wr_i.entry;
    end
    if (wr_i.vbit_we && sel) begin
      vbits[wr_row_i] <= wr_i.valid;
    end
    rd_q   <= mem[row_i];
    vbit_q <= vbits[row_i];
  end

  // Stage 1: token waits for the bank read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_i;
    cand_q <= cand_i;
    cidx_q <= cidx_i;
  end

  // Compare local entry against the incoming best; incoming has lower index
  assign match = vbit_q && (((rd_q.prefix ^ addr_i) & rd_q.mask) == '0);
  assign take  = match && (!cand_q.found || (rd_q.mask > cand_q.mask));

  always_comb begin
    cand_d = cand_q;
    cidx_d = cidx_q;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.mask  = rd_q.mask;
      cand_d.hop   = rd_q.hop;
      cand_d.port  = rd_q.port;
      cidx_d       = {row_q, rlpm_pkg::CELL_W'(CELL_ID)};
    end
  end

  // Stage 2: hand the result to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
    end else begin
      tok2_q <= tok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row2_q  <= row_q;
    cand2_q <= cand_d;
    cidx2_q <= cidx_d;
  end

  assign tok_o  = tok2_q;
  assign row_o  = row2_q;
  assign cand_o = cand2_q;
  assign cidx_o = cidx2_q;

endmodule

/* hdl/route_longest_prefix_match.sv */
// Channel   Dir  tuser          tdata
// s_axis    in   action         request: write one route or look up an address
// m_axis    out  hit            lookup result: next hop, port, matched slot
//
// Writes do not leave the idle state. A lookup streams every row of the table
// through a chain of 8 cells, one row per cycle, two register stages per cell,
// and the result is registered onto m_axis after the last row leaves the chain.
// After reset a clearing pass zeroes the valid bits of every row; no request is
// taken meanwhile. A result waiting on m_axis does not block new requests, but
// the next lookup result waits until it is taken.
module route_longest_prefix_match #(
  parameter int unsigned TABLE_DEPTH = rlpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // entry_index, entry_enable, route_prefix, route_mask, route_next_hop,
  // route_port, lookup_address, zero pad
  input  logic [rlpm_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  // action
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // next_hop_address, out_port, matched_index, zero pad
  output logic [rlpm_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  // hit
  output logic                            m_axis_tuser_o
);

  localparam int unsigned CELLS = rlpm_pkg::LPM_CELLS;
  localparam int unsigned ROWS  = (TABLE_DEPTH + CELLS - 1) / CELLS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IDX_W = ROW_W + rlpm_pkg::CELL_W;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [ROW_W-1:0]              cnt_q, cnt_d;
  logic [rlpm_pkg::ADDR_W-1:0]   addr_q;
  rlpm_pkg::s_data_t             s_data;
  rlpm_pkg::m_data_t             m_data_q;
  logic                          m_valid_q, m_hit_q;
  logic                          in_acc, is_lookup, in_range, out_free;
  rlpm_pkg::wr_t                 wr;
  logic [ROW_W-1:0]              wr_row;
  rlpm_pkg::cand_t               acc_q;
  logic [IDX_W-1:0]              acc_idx_q;

  rlpm_pkg::tok_t                tok_c  [CELLS+1];
  logic [ROW_W-1:0]              row_c  [CELLS+1];
  rlpm_pkg::cand_t               cand_c [CELLS+1];
  logic [IDX_W-1:0]              cidx_c [CELLS+1];

  assign s_data    = rlpm_pkg::s_data_t'(s_axis_tdata_i);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_lookup = (s_axis_tuser_i == rlpm_pkg::ACT_LOOKUP);
  assign in_range  = (32'(s_data.entry_index) < 32'(TABLE_DEPTH));
  assign out_free  = !m_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Control sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ROW_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && is_lookup) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ROW_LAST) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tok_c[CELLS].vld && tok_c[CELLS].last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Lookup address held for the whole scan
  always_ff @(posedge clk_i) begin
    if (in_acc && is_lookup) begin
      addr_q <= s_data.lookup_address;
    end
  end

  // Write and clearing commands to the cells
  always_comb begin
    wr.data_we      = in_acc && !is_lookup && in_range;
    wr.vbit_we      = wr.data_we || (state_q == ST_CLEAR);
    wr.bcast        = (state_q == ST_CLEAR);
    wr.valid        = (state_q != ST_CLEAR) && s_data.entry_enable;
    wr.bank         = s_data.entry_index[rlpm_pkg::CELL_W-1:0];
    wr.entry.prefix = s_data.route_prefix;
    wr.entry.mask   = s_data.route_mask;
    wr.entry.hop    = s_data.route_next_hop;
    wr.entry.port   = s_data.route_port;
    wr_row          = (state_q == ST_CLEAR) ? cnt_q
                                            : ROW_W'(s_data.entry_index >> rlpm_pkg::CELL_W);
  end

  // Row tokens enter the chain with an empty candidate
  assign tok_c[0].vld  = (state_q == ST_SCAN);
  assign tok_c[0].last = (cnt_q == ROW_LAST);
  assign row_c[0]      = cnt_q;
  assign cand_c[0]     = '0;
  assign cidx_c[0]     = '0;

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    rlpm_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .CELL_ID    (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .wr_row_i(wr_row),
      .addr_i  (addr_q),
      .tok_i   (tok_c[c]),
      .row_i   (row_c[c]),
      .cand_i  (cand_c[c]),
      .cidx_i  (cidx_c[c]),
      .tok_o   (tok_c[c+1]),
      .row_o   (row_c[c+1]),
      .cand_o  (cand_c[c+1]),
      .cidx_o  (cidx_c[c+1])
    );
  end

  // Fold per-row winners; rows arrive in rising index order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      acc_idx_q <= '0;
    end else if (in_acc && is_lookup) begin
      acc_q.found <= 1'b0;
    end else if (tok_c[CELLS].vld && cand_c[CELLS].found &&
                 (!acc_q.found || (cand_c[CELLS].mask > acc_q.mask))) begin
      acc_q     <= cand_c[CELLS];
      acc_idx_q <= cidx_c[CELLS];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      m_hit_q                   <= acc_q.found;
      m_data_q.pad              <= '0;
      m_data_q.next_hop_address <= acc_q.found ? acc_q.hop : '0;
      m_data_q.out_port         <= acc_q.found ? acc_q.port : '0;
      m_data_q.matched_index    <= acc_q.found ? rlpm_pkg::EIDX_W'(acc_idx_q) : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_hit_q;

endmodule

/* hdl/rlpm_checker.sv */
module rlpm_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [rlpm_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  input logic                          s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rlpm_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);

  // A lookup occupies the table scan, so the next cycle cannot take a request
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == rlpm_pkg::ACT_LOOKUP))
    |=> !s_axis_tready_o)
    else $error("ready high right after a lookup request");

  // A route write keeps s_axis ready for the next request
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == rlpm_pkg::ACT_WRITE))
    |=> s_axis_tready_o)
    else $error("ready dropped after a write request");

  // A miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("miss result with nonzero payload");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
    |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind route_longest_prefix_match rlpm_sva u_rlpm_sva (.*);
